// ===== hw/rtl/gain_scheduled_pd_steering_assert.svh =====
// Assertion macros for the gain scheduled PD steering block.
// Included by the checker; needs nothing else.
`ifndef GAIN_SCHEDULED_PD_STEERING_ASSERT_SVH
`define GAIN_SCHEDULED_PD_STEERING_ASSERT_SVH

// Checked only while out of reset.
`define GSPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gspd assertion failed");

// Checked on every edge, reset included.
`define GSPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gspd assertion failed");

`endif

// ===== hw/rtl/gspd_pkg.sv =====
// Shared types, codes and constant tables for the PD steering block.
// No dependencies; used by gspd_core, the top level and the checker.
package gspd_pkg;

  localparam int POSITION_BITS_DEF  = 11;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int MODE_W   = 3;
  localparam int SEL_W    = 2;
  localparam int NUM_SEL  = 4;
  localparam int NUM_BAND = 3;
  localparam int BAND_W   = 2;
  localparam int BONUS_W  = 6;
  localparam int BASE_W   = 9;
  localparam int TARGET_W = 13;
  localparam int TARGET_MIN = -4096;
  localparam int TARGET_MAX = 4095;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register index as decoded from the word address
  localparam logic REG_MODE = 1'b0;

  localparam logic [MODE_W-1:0] MODE_1     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_2     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_3     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_4     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_4;

  localparam logic [SEL_W-1:0] SEL_1 = 2'd0;
  localparam logic [SEL_W-1:0] SEL_2 = 2'd1;
  localparam logic [SEL_W-1:0] SEL_3 = 2'd2;
  localparam logic [SEL_W-1:0] SEL_4 = 2'd3;

  // Error bands: wide is |e| >= 66, mid is 35..65, narrow below 35
  localparam logic [BAND_W-1:0] BAND_WIDE   = 2'd0;
  localparam logic [BAND_W-1:0] BAND_MID    = 2'd1;
  localparam logic [BAND_W-1:0] BAND_NARROW = 2'd2;

  localparam int BAND_WIDE_MIN = 66;
  localparam int BAND_MID_MIN  = 35;
  localparam int SLOW_FULL_MAX = 30;
  localparam int SLOW_RAMP_MAX = 40;
  localparam int SLOW_BONUS    = 40;

  typedef struct packed {
    logic                 slowdown;
    logic [BONUS_W-1:0]   bonus;
  } gspd_bonus_t;

  function automatic logic [SEL_W-1:0] mode_sel(input logic [MODE_W-1:0] mode);
    logic [SEL_W-1:0] s;
    case (mode)
      MODE_1:  s = SEL_1;
      MODE_2:  s = SEL_2;
      MODE_3:  s = SEL_3;
      default: s = SEL_4;
    endcase
    return s;
  endfunction

  function automatic logic [BASE_W-1:0] base_speed(input logic [SEL_W-1:0] sel);
    logic [BASE_W-1:0] b;
    case (sel)
      SEL_1:   b = 9'd225;
      SEL_2:   b = 9'd225;
      SEL_3:   b = 9'd200;
      default: b = 9'd180;
    endcase
    return b;
  endfunction

  // Gains in hundredths; kd selects the derivative gain
  function automatic int gain_hundredths(input int sel, input int band, input bit kd);
    int g;
    g = 0;
    case (sel)
      SEL_1: case (band)
        BAND_WIDE: g = kd ? 90 : 80;
        BAND_MID:  g = kd ? 85 : 75;
        default:   g = kd ? 10 : 20;
      endcase
      SEL_2: case (band)
        BAND_WIDE: g = kd ? 50 : 65;
        BAND_MID:  g = kd ? 40 : 55;
        default:   g = kd ? 20 : 30;
      endcase
      SEL_3: case (band)
        BAND_WIDE: g = kd ? 100 : 50;
        BAND_MID:  g = kd ? 90 : 44;
        default:   g = kd ? 10 : 25;
      endcase
      default: case (band)
        BAND_WIDE: g = kd ? 100 : 39;
        BAND_MID:  g = kd ? 90 : 35;
        default:   g = kd ? 20 : 15;
      endcase
    endcase
    return g;
  endfunction

  // Hundredths to fixed point, rounded half up; elaboration only
  function automatic int to_fixed_gain(input int h, input int frac);
    return (h * (1 << frac) + 50) / 100;
  endfunction

endpackage

// ===== hw/rtl/gspd_core.sv =====
// Control law: band select, gain lookup, PD sum, speed bonus and target saturation.
// Purely combinational; depends on gspd_pkg.
module gspd_core #(
  parameter int POSITION_BITS  = gspd_pkg::POSITION_BITS_DEF,
  parameter int GAIN_FRAC_BITS = gspd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic [gspd_pkg::SEL_W-1:0]    sel,
  input  logic signed [POSITION_BITS-1:0] position,
  input  logic                          on_ramp,
  input  logic signed [POSITION_BITS-1:0] prev_error,
  input  gspd_pkg::gspd_bonus_t         bonus_st,
  output gspd_pkg::gspd_bonus_t         bonus_st_nxt,
  output logic [gspd_pkg::TARGET_W-1:0] left_target,
  output logic [gspd_pkg::TARGET_W-1:0] right_target
);
  import gspd_pkg::*;

  localparam int P      = POSITION_BITS;
  localparam int F      = GAIN_FRAC_BITS;
  localparam int GW     = F + 1;
  localparam int PD_W   = GW + P + 3;
  localparam int BASE_Q = F + 13;
  localparam int Q_W    = ((PD_W > BASE_Q) ? PD_W : BASE_Q) + 1;
  localparam int TW     = Q_W - F;
  localparam logic signed [TW-1:0] T_MIN = TW'(TARGET_MIN);
  localparam logic signed [TW-1:0] T_MAX = TW'(TARGET_MAX);

  logic [GW-1:0] kp_tab [NUM_SEL][NUM_BAND];
  logic [GW-1:0] kd_tab [NUM_SEL][NUM_BAND];

  for (genvar s = 0; s < NUM_SEL; s++) begin : g_sel
    for (genvar b = 0; b < NUM_BAND; b++) begin : g_band
      assign kp_tab[s][b] = GW'(to_fixed_gain(gain_hundredths(s, b, 1'b0), F));
      assign kd_tab[s][b] = GW'(to_fixed_gain(gain_hundredths(s, b, 1'b1), F));
    end
  end

  logic [P-1:0]             mag;
  logic [BAND_W-1:0]        band;
  logic [GW-1:0]            kp;
  logic [GW-1:0]            kd;
  logic signed [P:0]        diff;
  logic signed [GW+P:0]     prod_p;
  logic signed [GW+P+1:0]   prod_d;
  logic signed [Q_W-1:0]    pd;
  logic signed [Q_W-1:0]    base_q;
  logic [BASE_W:0]          base_sum;
  logic [7:0]               ramp_step;
  logic [BONUS_W-1:0]       bonus_taper;

  assign mag = position[P-1] ? (~position + 1'b1) : position;

  always_comb begin
    if (mag >= P'(BAND_WIDE_MIN)) begin
      band = BAND_WIDE;
    end else if (mag >= P'(BAND_MID_MIN)) begin
      band = BAND_MID;
    end else begin
      band = BAND_NARROW;
    end
  end

  assign kp = kp_tab[sel][band];
  assign kd = kd_tab[sel][band];

  // Bonus tapers by 4 per unit of |e| from 30 up to 40; only read when |e| < 40
  assign ramp_step   = (8'(mag) - 8'(SLOW_FULL_MAX)) << 2;
  assign bonus_taper = BONUS_W'(8'(SLOW_BONUS) - ramp_step);

  always_comb begin
    bonus_st_nxt = bonus_st;
    if (sel == SEL_1 && !on_ramp) begin
      if (mag < P'(SLOW_FULL_MAX)) begin
        bonus_st_nxt.bonus    = BONUS_W'(SLOW_BONUS);
        bonus_st_nxt.slowdown = 1'b1;
      end else if (bonus_st.slowdown && mag < P'(SLOW_RAMP_MAX)) begin
        bonus_st_nxt.bonus = bonus_taper;
      end else begin
        bonus_st_nxt.slowdown = 1'b0;
      end
    end else begin
      bonus_st_nxt.bonus = '0;
    end
  end

  assign diff   = {position[P-1], position} - {prev_error[P-1], prev_error};
  assign prod_p = $signed({1'b0, kp}) * position;
  assign prod_d = $signed({1'b0, kd}) * diff;
  assign pd     = Q_W'(prod_p) + Q_W'(prod_d);

  // Bonus is the value after this word's update
  assign base_sum = (BASE_W + 1)'(base_speed(sel)) + (BASE_W + 1)'(bonus_st_nxt.bonus);
  assign base_q   = $signed(Q_W'({base_sum, {F{1'b0}}}));

  // Drop the fraction toward zero, then clamp to the target range
  function automatic logic [TARGET_W-1:0] to_target(input logic signed [Q_W-1:0] q);
    logic signed [Q_W-1:0] adj;
    logic signed [TW-1:0]  t;
    adj = q + (q[Q_W-1] ? $signed(Q_W'({F{1'b1}})) : $signed(Q_W'(0)));
    t   = TW'(adj >>> F);
    if (t < T_MIN) begin
      t = T_MIN;
    end else if (t > T_MAX) begin
      t = T_MAX;
    end
    return t[TARGET_W-1:0];
  endfunction

  assign left_target  = to_target(base_q - pd);
  assign right_target = to_target(base_q + pd);

endmodule

// ===== hw/rtl/gain_scheduled_pd_steering.sv =====
// Top level of the gain scheduled PD steering controller: handshakes, state, mode register.
// Depends on gspd_pkg and gspd_core.
//
//   port group   direction  handshake        payload
//   in_          sink       in_valid/stall   position, on_ramp
//   out_         source     out_valid/stall  left_target, right_target
//   psel..       APB slave  psel/penable     mode register at byte 0
//
// Two register stages, input word then result; one word per cycle unless the result is stalled.
// out_valid rises as the word enters the result register; the law sits between the stages.
// in_stall rises only while both stages hold a word and the result is stalled.
// Synchronous active-low reset empties both stages, clears the controller state, mode to 4.
module gain_scheduled_pd_steering #(
  parameter int POSITION_BITS  = gspd_pkg::POSITION_BITS_DEF,
  parameter int GAIN_FRAC_BITS = gspd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [POSITION_BITS-1:0]    in_position,
  input  logic                               in_on_ramp,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [gspd_pkg::TARGET_W-1:0] out_left_target,
  output logic signed [gspd_pkg::TARGET_W-1:0] out_right_target,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gspd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [gspd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [gspd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import gspd_pkg::*;

  logic                            s1_valid_r;
  logic signed [POSITION_BITS-1:0] s1_position_r;
  logic                            s1_on_ramp_r;
  logic                            out_valid_r;
  logic [TARGET_W-1:0]             out_left_r;
  logic [TARGET_W-1:0]             out_right_r;
  logic signed [POSITION_BITS-1:0] prev_error_r;
  gspd_bonus_t                     bonus_st_r;
  gspd_bonus_t                     bonus_st_nxt;
  logic [MODE_W-1:0]               mode_r;
  logic [TARGET_W-1:0]             left_nxt;
  logic [TARGET_W-1:0]             right_nxt;
  logic                            out_adv;
  logic                            in_acc;
  logic                            s1_fire;
  logic                            cfg_wr;

  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && out_adv;
  assign cfg_wr   = psel && penable && pwrite && pready;

  gspd_core #(
    .POSITION_BITS  (POSITION_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .sel          (mode_sel(mode_r)),
    .position     (s1_position_r),
    .on_ramp      (s1_on_ramp_r),
    .prev_error   (prev_error_r),
    .bonus_st     (bonus_st_r),
    .bonus_st_nxt (bonus_st_nxt),
    .left_target  (left_nxt),
    .right_target (right_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_error_r <= '0;
      bonus_st_r   <= '0;
      mode_r       <= MODE_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      // Advance the controller state only as a word leaves the input stage
      if (s1_fire) begin
        prev_error_r <= s1_position_r;
        bonus_st_r   <= bonus_st_nxt;
      end
      if (cfg_wr && paddr[CFG_ADDR_W-1] == REG_MODE) begin
        mode_r <= pwdata[MODE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_position_r <= in_position;
      s1_on_ramp_r  <= in_on_ramp;
    end
    if (s1_fire) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_target  = out_left_r;
  assign out_right_target = out_right_r;

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_MODE) ? CFG_DATA_W'(mode_r) : '0;

endmodule

// ===== hw/rtl/gspd_checker.sv =====
// Port-level checks for the PD steering block, bound to its top level.
// Depends on gspd_pkg and gain_scheduled_pd_steering_assert.svh.
`include "gain_scheduled_pd_steering_assert.svh"

module gspd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [gspd_pkg::TARGET_W-1:0] out_left_target,
  input logic [gspd_pkg::TARGET_W-1:0] out_right_target
);
  import gspd_pkg::*;

  logic [2*TARGET_W-1:0] out_word;

  assign out_word = {out_left_target, out_right_target};

  // Reset empties the result stage
  `GSPD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // Input back-pressure only comes from a full, stalled result stage
  `GSPD_ASSERT(a_stall_source, clk, rst_n, in_stall |-> (out_valid && out_stall))

  // A stalled result word holds
  `GSPD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_word))

  // While the result side takes words the input never stalls
  `GSPD_ASSERT(a_no_stall_when_free, clk, rst_n, !out_stall |-> !in_stall)

endmodule

bind gain_scheduled_pd_steering gspd_checker u_gspd_checker (.*);

// ===== bench/tb_gain_scheduled_pd_steering.sv =====
// Self-checking bench for the gain scheduled PD steering controller: a queue-fed driver,
// a monitor and an in-order target predictor, stepped through every mode setting.
// Depends on gspd_pkg and the gain_scheduled_pd_steering RTL.
module tb_gain_scheduled_pd_steering;
  import gspd_pkg::*;

  localparam int POS_W        = POSITION_BITS_DEF;
  localparam int FRAC_W       = GAIN_FRAC_BITS_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 40;
  localparam int NUM_PHASES   = 10;

  // Byte addresses: the mode register, and one slot with no register behind it
  localparam logic [CFG_ADDR_W-1:0] ADDR_MODE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = 3'd4;

  // Unused mode codes, all of which fall back to mode 4
  localparam logic [MODE_W-1:0] MODE_SPARE_0 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    on_ramp;
  } sample_t;

  typedef struct packed {
    logic signed [TARGET_W-1:0] left;
    logic signed [TARGET_W-1:0] right;
  } targets_t;

  // Gains in hundredths per schedule and band (wide, mid, narrow), Kp then Kd
  int gain_pct [NUM_SEL][NUM_BAND][2] = '{
    '{'{80, 90},  '{75, 85}, '{20, 10}},
    '{'{65, 50},  '{55, 40}, '{30, 20}},
    '{'{50, 100}, '{44, 90}, '{25, 10}},
    '{'{39, 100}, '{35, 90}, '{15, 20}}
  };
  int base_spd [NUM_SEL] = '{225, 225, 200, 180};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [POS_W-1:0]     in_position = '0;
  logic                        in_on_ramp = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [TARGET_W-1:0]  out_left_target;
  logic signed [TARGET_W-1:0]  out_right_target;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]       paddr = '0;
  logic [CFG_DATA_W-1:0]       pwdata = '0;
  logic [CFG_DATA_W-1:0]       prdata;
  logic                        pready;

  sample_t  pending_samples [$];
  targets_t expected_targets [$];

  // Predictor state
  logic [MODE_W-1:0] cur_mode = MODE_RESET;
  int                prev_err = 0;
  bit                slow_on = 1'b0;
  int                bonus = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  gain_scheduled_pd_steering u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_position      (in_position),
    .in_on_ramp       (in_on_ramp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_target  (out_left_target),
    .out_right_target (out_right_target),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // Drop the fraction toward zero, then saturate to the target range
  function automatic logic signed [TARGET_W-1:0] to_target(input int q);
    int t;
    t = q / (1 << FRAC_W);
    if (t < TARGET_MIN) t = TARGET_MIN;
    if (t > TARGET_MAX) t = TARGET_MAX;
    return t[TARGET_W-1:0];
  endfunction

  function automatic void predict_targets(input sample_t s);
    int e, mag, sel, band, kp, kd, pd, base_q;
    targets_t t;
    e = s.position;
    mag = (e < 0) ? -e : e;
    case (cur_mode)
      MODE_1:  sel = SEL_1;
      MODE_2:  sel = SEL_2;
      MODE_3:  sel = SEL_3;
      default: sel = SEL_4;
    endcase
    if (mag >= BAND_WIDE_MIN)     band = BAND_WIDE;
    else if (mag >= BAND_MID_MIN) band = BAND_MID;
    else                          band = BAND_NARROW;
    kp = (gain_pct[sel][band][0] * (1 << FRAC_W) + 50) / 100;
    kd = (gain_pct[sel][band][1] * (1 << FRAC_W) + 50) / 100;

    // Slowdown bonus lives in mode 1 off ramp only; leaving the window keeps the old bonus
    if (sel == SEL_1 && !s.on_ramp) begin
      if (mag < SLOW_FULL_MAX) begin
        bonus = SLOW_BONUS;
        slow_on = 1'b1;
      end else if (slow_on && mag < SLOW_RAMP_MAX) begin
        bonus = SLOW_BONUS - (mag - SLOW_FULL_MAX) * 4;
      end else begin
        slow_on = 1'b0;
      end
    end else begin
      bonus = 0;
    end

    pd = kp * e + kd * (e - prev_err);
    prev_err = e;
    base_q = (base_spd[sel] + bonus) * (1 << FRAC_W);
    t.left = to_target(base_q - pd);
    t.right = to_target(base_q + pd);
    expected_targets.push_back(t);
  endfunction

  // Driver: predict on acceptance, then present the next word or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_targets('{position: in_position, on_ramp: in_on_ramp});
      if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_position <= s.position;
        in_on_ramp <= s.on_ramp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_targets.size() == 0) begin
          report_mismatch("unexpected word, left", out_left_target, 0);
        end else begin
          targets_t want;
          want = expected_targets.pop_front();
          if (out_left_target !== want.left)
            report_mismatch("left_target", out_left_target, want.left);
          if (out_right_target !== want.right)
            report_mismatch("right_target", out_right_target, want.right);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               expected_targets.size());
      $display("tb_gain_scheduled_pd_steering: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [MODE_W-1:0] val);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[MODE_W-1:0] = val;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MODE) cur_mode = val;
  endtask

  // Hold until every queued word is through and the pipeline has settled
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_targets.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_sample(input int pos, input bit ramp);
    sample_t s;
    s.position = pos[POS_W-1:0];
    s.on_ramp = ramp;
    pending_samples.push_back(s);
  endtask

  initial begin
    int reset_pos [4] = '{1023, -1024, 0, 50};
    // Slowdown walk: enter, taper, leave with bonus kept, ramp, re-enter, band edges
    int walk_pos [20] = '{0, 29, 30, 35, -39, 40, 34, -29, 10, 33,
                          65, 66, -66, -65, 1023, -1024, -1024, 1023, -30, 0};
    bit walk_ramp [20] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0,
                           0, 0, 0, 0, 0, 0, 1, 1, 0, 0};
    logic [MODE_W-1:0] phase_mode [NUM_PHASES] = '{MODE_1, MODE_SPARE_0, MODE_2, MODE_1,
      MODE_3, MODE_SPARE_5, MODE_4, MODE_SPARE_6, MODE_1, MODE_SPARE_7};
    int pick, mag, pos;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 30;
    recv_stall_pct = 30;
    foreach (reset_pos[i]) queue_sample(reset_pos[i], 1'b0);
    drain();
    write_reg(ADDR_MODE, MODE_1);
    foreach (walk_pos[i]) queue_sample(walk_pos[i], walk_ramp[i]);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      // A write to an empty slot must leave the mode alone
      if (ph == 5) write_reg(ADDR_SPARE, MODE_W'($urandom_range(0, 7)));
      write_reg(ADDR_MODE, phase_mode[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          mag = (pick < 6) ? $urandom_range(0, 45) : $urandom_range(0, 80);
          pos = $urandom_range(0, 1) ? -mag : mag;
        end else begin
          pos = $urandom;
        end
        queue_sample(pos, $urandom_range(0, 4) == 0);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_gain_scheduled_pd_steering: PASS");
    end else begin
      $display("tb_gain_scheduled_pd_steering: FAIL");
    end
    $finish;
  end

endmodule
